// ----- sv/llm_pkg.sv -----
// ----------------------------------------------------------------------------
// llm_pkg
// Shared constants, register map and byte helpers for the literal line matcher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package llm_pkg;

  localparam int PATTERN_MAX   = 16;
  localparam int POSITION_BITS = 16;
  localparam int WIN           = PATTERN_MAX + 1;
  localparam int LEN_W         = $clog2(PATTERN_MAX + 1);
  localparam int WIN_IDX_W     = $clog2(WIN);

  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 6;
  localparam int CFG_IDX_W  = 3;

  localparam int IN_DATA_W  = 8;
  localparam int OUT_FLD_W  = 1 + POSITION_BITS + LEN_W + 1;
  localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;

  localparam logic [7:0] CH_LA = 8'h61;  // 'a'
  localparam logic [7:0] CH_LZ = 8'h7A;  // 'z'
  localparam logic [7:0] CH_UA = 8'h41;  // 'A'
  localparam logic [7:0] CH_UZ = 8'h5A;  // 'Z'
  localparam logic [7:0] CH_D0 = 8'h30;  // '0'
  localparam logic [7:0] CH_D9 = 8'h39;  // '9'
  localparam logic [7:0] CH_US = 8'h5F;  // '_'
  localparam logic [7:0] CASE_OFS = 8'h20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LOW    = 3'd0,
    REG_PATTERN_HIGH   = 3'd1,
    REG_PATTERN_LENGTH = 3'd2,
    REG_CASE_SENSITIVE = 3'd3,
    REG_MATCH_SCOPE    = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SCOPE_ANY  = 2'd0,
    SCOPE_WORD = 2'd1,
    SCOPE_LINE = 2'd2,
    SCOPE_RSVD = 2'd3
  } scope_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic exact);
    if (!exact && c >= CH_UA && c <= CH_UZ) begin
      return c + CASE_OFS;
    end
    return c;
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ) ||
           (c >= CH_D0 && c <= CH_D9) || (c == CH_US);
  endfunction

endpackage

// ----- sv/literal_line_matcher_top.sv -----
// ----------------------------------------------------------------------------
// literal_line_matcher_top
// Leftmost fixed-string search over text lines, one byte per transaction.
// ----------------------------------------------------------------------------
// Feed one byte of a line per transaction on the in_ stream, with in_tlast on
// the last byte. The block accepts a byte in every cycle while the out_ stream
// keeps up: the pattern compare over the sliding window is a fixed parallel
// compare that sits between the line-state registers and the result register.
// One result transaction leaves on the out_ stream for every line; the result
// of its last byte is registered in the output register or its skid stage. A
// two-deep output register keeps the input stream moving while one result
// waits, and the input stalls only while both output stages hold a result.
// Program the pattern and modes through the cfg_ port between lines; a change
// takes effect from the next byte.
`timescale 1ns / 1ps

module literal_line_matcher_top
  import llm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [7:0] char_byte
  input  logic                  in_tlast,   // end_of_line

  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [0] found, [16:1] match_start,
                                            // [21:17] match_length,
                                            // [22] line_overflow, rest zero

  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic [63:0]      pat_low_r, pat_high_r;
  logic [LEN_W-1:0] pat_len_r;
  logic             case_sens_r;
  logic [1:0]       scope_r;

  logic [7:0]               recent_r [PATTERN_MAX];
  logic [POSITION_BITS-1:0] seen_r, seen_nxt;
  logic                     hit_r, hit_nxt;
  logic [POSITION_BITS-1:0] hit_start_r, hit_start_nxt;
  logic                     cand_r, cand_nxt;
  logic [POSITION_BITS-1:0] cand_start_r, cand_start_nxt;
  logic                     ovf_r, ovf_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                  skid_valid_r, skid_valid_nxt;
  logic [OUT_DATA_W-1:0] skid_data_r, skid_data_nxt;

  logic                  in_acc;
  logic                  cfg_wr;
  cfg_reg_t              cfg_idx;
  logic [7:0]            b;
  logic [127:0]          pat_all;
  logic [7:0]            win [WIN];
  logic [7:0]            fwin [PATTERN_MAX];
  logic [7:0]            fpat [PATTERN_MAX];
  logic [PATTERN_MAX:0]  lmatch;
  logic [LEN_W-1:0]      len;
  logic [POSITION_BITS-1:0] pos;
  logic [POSITION_BITS:0]   pos_p1;
  logic                  sat;
  logic                  det;
  logic [POSITION_BITS-1:0] start;
  logic                  before_ok;
  logic                  found;
  logic [POSITION_BITS-1:0] fstart;
  logic [LEN_W-1:0]      flen;
  logic [OUT_DATA_W-1:0] res_data;
  logic                  res_valid;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_reg_t'(cfg_paddr[CFG_ADDR_W-1:CFG_ADDR_W-CFG_IDX_W]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r   <= '0;
      pat_high_r  <= '0;
      pat_len_r   <= LEN_W'(1);
      case_sens_r <= 1'b1;
      scope_r     <= SCOPE_ANY;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_PATTERN_LOW:    pat_low_r   <= cfg_pwdata;
        REG_PATTERN_HIGH:   pat_high_r  <= cfg_pwdata;
        REG_PATTERN_LENGTH: pat_len_r   <= cfg_pwdata[LEN_W-1:0];
        REG_CASE_SENSITIVE: case_sens_r <= cfg_pwdata[0];
        REG_MATCH_SCOPE:    scope_r     <= cfg_pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_PATTERN_LOW:    cfg_prdata = pat_low_r;
      REG_PATTERN_HIGH:   cfg_prdata = pat_high_r;
      REG_PATTERN_LENGTH: cfg_prdata = CFG_DATA_W'(pat_len_r);
      REG_CASE_SENSITIVE: cfg_prdata = CFG_DATA_W'(case_sens_r);
      REG_MATCH_SCOPE:    cfg_prdata = CFG_DATA_W'(scope_r);
      default:            cfg_prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Window compare
  // --------------------------------------------------------------------------
  assign in_tready = !skid_valid_r;
  assign in_acc    = in_tvalid && in_tready;
  assign b         = in_tdata[7:0];
  assign pat_all   = {pat_high_r, pat_low_r};
  assign len       = (pat_len_r > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : pat_len_r;

  always_comb begin
    win[0] = b;
    for (int k = 1; k < WIN; k++) begin
      win[k] = recent_r[k-1];
    end
    for (int k = 0; k < PATTERN_MAX; k++) begin
      fwin[k] = fold_byte(win[k], case_sens_r);
      fpat[k] = fold_byte(pat_all[8*k +: 8], case_sens_r);
    end
  end

  always_comb begin
    lmatch[0] = 1'b0;
    for (int l = 1; l <= PATTERN_MAX; l++) begin
      lmatch[l] = 1'b1;
      for (int i = 0; i < l; i++) begin
        if (fwin[l-1-i] != fpat[i]) begin
          lmatch[l] = 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Line state and result
  // --------------------------------------------------------------------------
  always_comb begin
    sat      = (seen_r == POS_MAX);
    pos      = sat ? POS_MAX : seen_r;
    seen_nxt = sat ? seen_r : seen_r + POSITION_BITS'(1);
    ovf_nxt  = ovf_r || sat;
    pos_p1   = {1'b0, pos} + (POSITION_BITS+1)'(1);

    det   = (len != '0) && (pos_p1 >= (POSITION_BITS+1)'(len)) && lmatch[len];
    start = sat ? POS_MAX : POSITION_BITS'(pos_p1 - (POSITION_BITS+1)'(len));
    before_ok = ((start == '0) && !sat) || !is_word(win[WIN_IDX_W'(len)]);

    hit_nxt        = hit_r;
    hit_start_nxt  = hit_start_r;
    cand_nxt       = cand_r;
    cand_start_nxt = cand_start_r;

    unique case (scope_t'(scope_r))
      SCOPE_WORD: begin
        if (cand_r && !hit_r && !is_word(b)) begin
          hit_nxt       = 1'b1;
          hit_start_nxt = cand_start_r;
        end
        cand_nxt = 1'b0;
        if (det && !hit_nxt && before_ok) begin
          cand_nxt       = 1'b1;
          cand_start_nxt = start;
        end
      end
      SCOPE_LINE: ;
      SCOPE_ANY, SCOPE_RSVD: begin
        if (det && !hit_r) begin
          hit_nxt       = 1'b1;
          hit_start_nxt = start;
        end
      end
      default: ;
    endcase

    found  = 1'b0;
    fstart = '0;
    if (scope_t'(scope_r) == SCOPE_LINE) begin
      found = !ovf_nxt && (pos_p1 == (POSITION_BITS+1)'(len)) && det;
    end else begin
      found  = hit_nxt || ((scope_t'(scope_r) == SCOPE_WORD) && cand_nxt);
      fstart = hit_nxt ? hit_start_nxt : (found ? cand_start_nxt : '0);
    end
    flen = found ? len : '0;

    res_data  = OUT_DATA_W'({ovf_nxt, flen, fstart, found});
    res_valid = in_acc && in_tlast;

    if (res_valid) begin
      seen_nxt = '0;
      hit_nxt  = 1'b0;
      hit_start_nxt = '0;
      cand_nxt = 1'b0;
      cand_start_nxt = '0;
      ovf_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r       <= '0;
      hit_r        <= 1'b0;
      hit_start_r  <= '0;
      cand_r       <= 1'b0;
      cand_start_r <= '0;
      ovf_r        <= 1'b0;
    end else if (in_acc) begin
      seen_r       <= seen_nxt;
      hit_r        <= hit_nxt;
      hit_start_r  <= hit_start_nxt;
      cand_r       <= cand_nxt;
      cand_start_r <= cand_start_nxt;
      ovf_r        <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int k = 0; k < PATTERN_MAX; k++) begin
        recent_r[k] <= win[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register with skid stage
  // --------------------------------------------------------------------------
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (out_tready) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (!out_valid_r || out_tready) begin
      out_valid_nxt = res_valid;
      out_data_nxt  = res_data;
    end else if (res_valid) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage holds a result while output register is empty");

  a_len_tracks_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[0] == (out_data_r[POSITION_BITS+LEN_W:POSITION_BITS+1] != '0)))
    else $error("match length disagrees with found");

  a_ovf_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (seen_r == POS_MAX))
    else $error("overflow set without saturated position");

  a_line_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tlast) |=> (seen_r == '0 && !hit_r && !cand_r && !ovf_r))
    else $error("line state not cleared after end of line");

endmodule
